// ===== rtl/psg_pkg.sv =====
package psg_pkg;

   localparam int STEP_W     = 32;
   localparam int PER_W      = 10;
   localparam int VOL_W      = 14;
   localparam int LFSR_W     = 15;
   localparam int DIV_W      = 11;
   localparam int CNT_W      = 6;
   localparam int NUM_VOICES = 4;
   localparam int NUM_TONES  = 3;

   localparam logic [CNT_W-1:0]  DIV_LAST = 6'd31;
   localparam logic [CNT_W-1:0]  ADD_LAST = 6'd32;
   localparam logic [CNT_W-1:0]  STEP_BITS = 6'd32;

   localparam logic [STEP_W-1:0] STEP_NUM_RESET = 32'd85111488;
   localparam logic [LFSR_W-1:0] SEED_RESET     = 15'd16384;

   localparam logic [LFSR_W-1:0] PERIOD_WHITE    = 15'h7fff;
   localparam logic [LFSR_W-1:0] PERIOD_ROTATE   = 15'd15;
   localparam logic [DIV_W-1:0]  ZERO_PERIOD_DIV = 11'h400;
   localparam logic [DIV_W-1:0]  NOISE_DIV_BASE  = 11'd16;

   localparam logic       FUNC_WRITE = 1'b0;
   localparam logic       FUNC_TICK  = 1'b1;
   localparam logic       CSR_IDX_STEP_NUM = 1'b0;
   localparam logic       CSR_IDX_SEED     = 1'b1;

   localparam logic [2:0] REG_TONE0      = 3'd0;
   localparam logic [2:0] REG_TONE1      = 3'd2;
   localparam logic [2:0] REG_TONE2      = 3'd4;
   localparam logic [2:0] REG_NOISE_CTRL = 3'd6;

   localparam logic [1:0] CHAN_TONE2 = 2'd2;
   localparam logic [1:0] CHAN_NOISE = 2'd3;
   localparam logic [1:0] RATE_TONE2 = 2'd3;

   typedef logic [VOL_W-1:0] vol_type;

   function automatic vol_type vol_lookup(input logic [3:0] att);
      vol_type v;
      case (att)
         4'd0:    v = 14'd8191;
         4'd1:    v = 14'd6506;
         4'd2:    v = 14'd5168;
         4'd3:    v = 14'd4105;
         4'd4:    v = 14'd3261;
         4'd5:    v = 14'd2590;
         4'd6:    v = 14'd2057;
         4'd7:    v = 14'd1634;
         4'd8:    v = 14'd1298;
         4'd9:    v = 14'd1031;
         4'd10:   v = 14'd819;
         4'd11:   v = 14'd651;
         4'd12:   v = 14'd517;
         4'd13:   v = 14'd411;
         4'd14:   v = 14'd326;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/three_tone_one_noise_psg.sv =====
// Sound generator with three square-wave tones and one noise voice. A req word with
// tuser 0 is a register byte (latch/data scheme); one with tuser 1 is a tick that
// returns one signed sample, minus the sum of sounding volumes. A volume write needs
// no division; a period write, or a noise control write with a fixed rate, runs through
// the one-bit-per-cycle restoring divider that forms the step. A tick runs the four
// bit-serial phase adders, then clocks the LFSR once per unit of the noise wrap count
// (reduced modulo 15 in periodic mode, modulo 32767 in white mode, so usually 0 or 1),
// then leaves that stage and loads the result register; the load waits while an
// earlier sample is still unaccepted. One word is worked on at a time. csr register 0
// (byte 0) is step_numerator, register 1 (byte 4) is lfsr_seed.
module three_tone_one_noise_psg #(
   parameter int FRAC_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample (signed)
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ADD, ST_LFSR, ST_EMIT} state_type;

   localparam logic [psg_pkg::CNT_W-1:0] FRAC_CNT = psg_pkg::CNT_W'(FRAC_WIDTH);

   logic [psg_pkg::STEP_W-1:0] step_num_ff, step_num_in;
   logic [psg_pkg::LFSR_W-1:0] seed_ff, seed_in;
   logic [psg_pkg::PER_W-1:0]  period_ff [psg_pkg::NUM_TONES];
   logic [psg_pkg::PER_W-1:0]  period_in [psg_pkg::NUM_TONES];
   logic [psg_pkg::STEP_W-1:0] step_ff [psg_pkg::NUM_VOICES];
   logic [psg_pkg::STEP_W-1:0] step_in [psg_pkg::NUM_VOICES];
   psg_pkg::vol_type           vol_ff [psg_pkg::NUM_VOICES];
   psg_pkg::vol_type           vol_in [psg_pkg::NUM_VOICES];
   logic [FRAC_WIDTH-1:0]      acc_ff [psg_pkg::NUM_VOICES];
   logic [FRAC_WIDTH-1:0]      acc_in [psg_pkg::NUM_VOICES];
   logic [psg_pkg::NUM_VOICES-1:0] carry_ff, carry_in;
   logic [1:0]                 latched_ff, latched_in;
   logic [2:0]                 mode_ff, mode_in;
   logic [psg_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in;
   state_type                  state_ff, state_in;
   logic [psg_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [psg_pkg::STEP_W-1:0] quo_ff, quo_in;
   logic [psg_pkg::DIV_W-1:0]  drem_ff, drem_in;
   logic [psg_pkg::DIV_W-1:0]  divisor_ff, divisor_in;
   logic [1:0]                 target_ff, target_in;
   logic [psg_pkg::LFSR_W-1:0] wrap_ff, wrap_in;
   logic [psg_pkg::LFSR_W-1:0] weight_ff, weight_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                sample_ff, sample_in;

   logic [psg_pkg::LFSR_W-1:0] modulus;
   logic                       csr_write;

   assign modulus    = mode_ff[2] ? psg_pkg::PERIOD_WHITE : psg_pkg::PERIOD_ROTATE;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == psg_pkg::CSR_IDX_SEED) ?
                       {17'd0, seed_ff} : step_num_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sample_ff;

   always_comb begin
      logic [2:0]                 reg_sel;
      logic [1:0]                 chan;
      logic [psg_pkg::PER_W-1:0]  new_per;
      logic [psg_pkg::DIV_W:0]    dtrial;
      logic                       dge;
      logic [psg_pkg::STEP_W-1:0] quotient;
      logic [psg_pkg::NUM_VOICES-1:0] lane_a, lane_s, lane_sum;
      logic [psg_pkg::LFSR_W:0]   mod_sum, dbl;
      logic [15:0]                vol_sum;

      step_num_in  = step_num_ff;
      seed_in      = seed_ff;
      period_in    = period_ff;
      step_in      = step_ff;
      vol_in       = vol_ff;
      acc_in       = acc_ff;
      carry_in     = carry_ff;
      latched_in   = latched_ff;
      mode_in      = mode_ff;
      lfsr_in      = lfsr_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      drem_in      = drem_ff;
      divisor_in   = divisor_ff;
      target_in    = target_ff;
      wrap_in      = wrap_ff;
      weight_in    = weight_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;

      reg_sel  = req_tdata[7] ? req_tdata[6:4] : {latched_ff, 1'b0};
      chan     = reg_sel[2:1];
      new_per  = '0;
      dtrial   = {drem_ff, quo_ff[psg_pkg::STEP_W-1]};
      dge      = (dtrial >= {1'b0, divisor_ff});
      quotient = {quo_ff[psg_pkg::STEP_W-2:0], dge};
      lane_a   = '0;
      lane_s   = '0;
      lane_sum = '0;
      mod_sum  = {1'b0, wrap_ff} + {1'b0, weight_ff};
      if (mod_sum >= {1'b0, modulus})
         mod_sum = mod_sum - {1'b0, modulus};
      dbl = {weight_ff, 1'b0};
      if (dbl >= {1'b0, modulus})
         dbl = dbl - {1'b0, modulus};
      vol_sum = 16'(vol_ff[0] & {psg_pkg::VOL_W{acc_ff[0][FRAC_WIDTH-1]}})
              + 16'(vol_ff[1] & {psg_pkg::VOL_W{acc_ff[1][FRAC_WIDTH-1]}})
              + 16'(vol_ff[2] & {psg_pkg::VOL_W{acc_ff[2][FRAC_WIDTH-1]}})
              + 16'(vol_ff[3] & {psg_pkg::VOL_W{lfsr_ff[0]}});

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == psg_pkg::FUNC_TICK) begin
                  state_in  = ST_ADD;
                  cnt_in    = '0;
                  carry_in  = '0;
                  wrap_in   = '0;
                  weight_in = psg_pkg::LFSR_W'(1);
               end else if (req_tdata[7] || latched_ff != psg_pkg::CHAN_NOISE) begin
                  case (reg_sel)
                     psg_pkg::REG_TONE0, psg_pkg::REG_TONE1, psg_pkg::REG_TONE2: begin
                        latched_in = chan;
                        new_per = req_tdata[7] ?
                                  {period_ff[chan][9:4], req_tdata[3:0]} :
                                  {req_tdata[5:0], period_ff[chan][3:0]};
                        period_in[chan] = new_per;
                        divisor_in = (new_per == '0) ? psg_pkg::ZERO_PERIOD_DIV :
                                     {1'b0, new_per};
                        target_in = chan;
                        quo_in    = step_num_ff;
                        drem_in   = '0;
                        cnt_in    = '0;
                        state_in  = ST_DIV;
                     end
                     psg_pkg::REG_NOISE_CTRL: begin
                        latched_in = psg_pkg::CHAN_NOISE;
                        if (req_tdata[2] != mode_ff[2])
                           lfsr_in = seed_ff;
                        mode_in = req_tdata[2:0];
                        if (req_tdata[1:0] == psg_pkg::RATE_TONE2) begin
                           step_in[3] = step_ff[2];
                        end else begin
                           divisor_in = psg_pkg::NOISE_DIV_BASE << req_tdata[1:0];
                           target_in  = psg_pkg::CHAN_NOISE;
                           quo_in     = step_num_ff;
                           drem_in    = '0;
                           cnt_in     = '0;
                           state_in   = ST_DIV;
                        end
                     end
                     default: begin
                        vol_in[chan] = psg_pkg::vol_lookup(req_tdata[3:0]);
                     end
                  endcase
               end
            end
         end
         ST_DIV: begin
            drem_in = dge ? psg_pkg::DIV_W'(dtrial - {1'b0, divisor_ff}) :
                            psg_pkg::DIV_W'(dtrial);
            quo_in  = quotient;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == psg_pkg::DIV_LAST) begin
               state_in = ST_IDLE;
               step_in[target_ff] = quotient;
               if (target_ff == psg_pkg::CHAN_TONE2 && mode_ff[1:0] == psg_pkg::RATE_TONE2)
                  step_in[3] = quotient;
            end
         end
         ST_ADD: begin
            for (int v = 0; v < psg_pkg::NUM_VOICES; v++) begin
               lane_a[v]   = (cnt_ff < FRAC_CNT) ? acc_ff[v][0] : 1'b0;
               lane_s[v]   = (cnt_ff < psg_pkg::STEP_BITS) ? step_ff[v][0] : 1'b0;
               lane_sum[v] = lane_a[v] ^ lane_s[v] ^ carry_ff[v];
               carry_in[v] = (lane_a[v] & lane_s[v]) | (lane_a[v] & carry_ff[v])
                           | (lane_s[v] & carry_ff[v]);
               if (cnt_ff < FRAC_CNT)
                  acc_in[v] = {lane_sum[v], acc_ff[v][FRAC_WIDTH-1:1]};
               if (cnt_ff < psg_pkg::STEP_BITS)
                  step_in[v] = {step_ff[v][0], step_ff[v][psg_pkg::STEP_W-1:1]};
            end
            if (cnt_ff >= FRAC_CNT) begin
               if (lane_sum[3])
                  wrap_in = psg_pkg::LFSR_W'(mod_sum);
               weight_in = psg_pkg::LFSR_W'(dbl);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == psg_pkg::ADD_LAST)
               state_in = ST_LFSR;
         end
         ST_LFSR: begin
            if (wrap_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               lfsr_in = {mode_ff[2] ? (lfsr_ff[0] ^ ~lfsr_ff[4]) : lfsr_ff[0],
                          lfsr_ff[psg_pkg::LFSR_W-1:1]};
               wrap_in = wrap_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               sample_in    = 16'd0 - vol_sum;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         if (csr_paddr[2] == psg_pkg::CSR_IDX_SEED)
            seed_in = csr_pwdata[psg_pkg::LFSR_W-1:0];
         else
            step_num_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_num_ff  <= psg_pkg::STEP_NUM_RESET;
         seed_ff      <= psg_pkg::SEED_RESET;
         lfsr_ff      <= psg_pkg::SEED_RESET;
         latched_ff   <= '0;
         mode_ff      <= '0;
         cnt_ff       <= '0;
         for (int i = 0; i < psg_pkg::NUM_TONES; i++)
            period_ff[i] <= '0;
         for (int i = 0; i < psg_pkg::NUM_VOICES; i++) begin
            step_ff[i] <= '0;
            vol_ff[i]  <= '0;
            acc_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_num_ff  <= step_num_in;
         seed_ff      <= seed_in;
         lfsr_ff      <= lfsr_in;
         latched_ff   <= latched_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         period_ff    <= period_in;
         step_ff      <= step_in;
         vol_ff       <= vol_in;
         acc_ff       <= acc_in;
      end
      carry_ff   <= carry_in;
      quo_ff     <= quo_in;
      drem_ff    <= drem_in;
      divisor_ff <= divisor_in;
      target_ff  <= target_in;
      wrap_ff    <= wrap_in;
      weight_ff  <= weight_in;
      sample_ff  <= sample_in;
   end

`ifndef SYNTH
   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (cnt_ff <= psg_pkg::ADD_LAST))
      else $error("bit-serial add ran past its last bit");

   a_wrap_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD || state_ff == ST_LFSR) |-> (wrap_ff < modulus))
      else $error("noise wrap count not reduced below LFSR period");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (drem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word raised outside emit");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_ADD) |=>
      (state_ff != ST_EMIT || $past(state_ff == ST_ADD)))
      else $error("emit reached from divider");
`endif

endmodule
